FILE: hw/rtl/ucbd_pkg.sv
package ucbd_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int OUT_WIDTH = 32;

   localparam int IN_DEPTH = 2;
   localparam int IN_PTR_W = $clog2(IN_DEPTH);
   localparam int IN_CNT_W = $clog2(IN_DEPTH + 1);

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_OMEGA = 2'd0,
      MODE_DELTA = 2'd1,
      MODE_GAMMA = 2'd2,
      MODE_FIB   = 2'd3
   } code_mode_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_beat_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] value;
      logic                 ovf;
      logic                 last;
   } rsp_item_type;

   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

endpackage

FILE: hw/rtl/ucbd_front.sv
module ucbd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_stream_byte,
   output ucbd_pkg::byte_beat_type beat,
   input  logic                   pop
);
   import ucbd_pkg::*;

   logic [7:0]          q_ff [IN_DEPTH];
   logic [IN_PTR_W-1:0] rd_ff, rd_in;
   logic [IN_PTR_W-1:0] wr_ff, wr_in;
   logic [IN_CNT_W-1:0] cnt_ff, cnt_in;
   logic                push;
   logic                do_pop;

   assign req_stall  = (cnt_ff == IN_CNT_W'(IN_DEPTH));
   assign push       = req_valid && !req_stall;
   assign beat.valid = (cnt_ff != '0);
   assign beat.data  = q_ff[rd_ff];
   assign do_pop     = pop && beat.valid;

   always_comb begin
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == IN_PTR_W'(IN_DEPTH - 1)) ? '0 : wr_ff + IN_PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == IN_PTR_W'(IN_DEPTH - 1)) ? '0 : rd_ff + IN_PTR_W'(1);
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + IN_CNT_W'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - IN_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= req_stream_byte;
      end
   end

endmodule

FILE: hw/rtl/ucbd_back.sv
module ucbd_back #(
   parameter int VALUE_WIDTH = ucbd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [1:0]              csr_wr_data,
   input  ucbd_pkg::byte_beat_type in_beat,
   output logic                    in_pop,
   input  logic                    out_room,
   output ucbd_pkg::rsp_push_type  push
);
   import ucbd_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int EW = VALUE_WIDTH + OUT_WIDTH;
   localparam logic [W-1:0] VMAX = '1;
   localparam logic [W-1:0] ONE  = W'(1);
   localparam logic [W-1:0] TWO  = W'(2);
   localparam logic [6:0]   LEN_MAX = 7'd127;

   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_FIELD = 2'd1;
   localparam logic [1:0] PH_TAIL  = 2'd2;

   function automatic logic [6:0] cap_len(input logic [W-1:0] x);
      cap_len = (|x[W-1:7]) ? LEN_MAX : x[6:0];
   endfunction

   logic [1:0]   mode_ff, mode_in;
   logic [1:0]   phase_ff, phase_in;
   logic [6:0]   zero_run_ff, zero_run_in;
   logic [6:0]   bits_left_ff, bits_left_in;
   logic [W-1:0] accum_ff, accum_in;
   logic [W-1:0] group_ff, group_in;
   logic [W-1:0] fib_lo_ff, fib_lo_in;
   logic [W-1:0] fib_hi_ff, fib_hi_in;
   logic [W-1:0] fib_sum_ff, fib_sum_in;
   logic         prev_one_ff, prev_one_in;
   logic         sticky_ff, sticky_in;
   logic         held_valid_ff, held_valid_in;
   rsp_item_type held_ff, held_in;
   logic [7:0]   cur_ff, cur_in;
   logic [2:0]   bit_idx_ff, bit_idx_in;
   logic         have_ff, have_in;

   logic         step;
   logic         b;
   logic         last_bit;
   logic         sh_ovf;
   logic [W-1:0] sh_val;
   logic [6:0]   bl_dec;
   logic         emit;
   logic [W-1:0] emit_n;
   logic         sticky_mid;
   logic [W-1:0] emit_v;
   logic [EW-1:0] emit_ext;
   logic [W:0]   sum_add;
   logic [W:0]   wgt_add;
   rsp_item_type new_item;
   rsp_item_type held_last;

   assign step     = have_ff && out_room;
   assign b        = cur_ff[bit_idx_ff];
   assign last_bit = (bit_idx_ff == 3'd0);
   assign sh_ovf   = accum_ff[W-1];
   assign sh_val   = sh_ovf ? VMAX : {accum_ff[W-2:0], b};
   assign bl_dec   = (bits_left_ff != 7'd0) ? bits_left_ff - 7'd1 : 7'd0;
   assign sum_add  = {1'b0, fib_sum_ff} + {1'b0, fib_lo_ff};
   assign wgt_add  = {1'b0, fib_lo_ff} + {1'b0, fib_hi_ff};
   assign in_pop   = in_beat.valid && (!have_ff || (step && last_bit));

   // bit-serial decode, one stream bit per step
   always_comb begin
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      zero_run_in  = zero_run_ff;
      bits_left_in = bits_left_ff;
      accum_in     = accum_ff;
      group_in     = group_ff;
      fib_lo_in    = fib_lo_ff;
      fib_hi_in    = fib_hi_ff;
      fib_sum_in   = fib_sum_ff;
      prev_one_in  = prev_one_ff;
      sticky_mid   = sticky_ff;
      emit         = 1'b0;
      emit_n       = ONE;

      case (mode_ff)
         MODE_OMEGA: begin
            if (phase_ff == PH_START) begin
               if (!b) begin
                  emit     = 1'b1;
                  emit_n   = group_ff;
                  group_in = ONE;
               end else begin
                  accum_in     = ONE;
                  bits_left_in = cap_len(group_ff);
                  phase_in     = PH_FIELD;
               end
            end else begin
               accum_in     = sh_val;
               sticky_mid   = sticky_ff | sh_ovf;
               bits_left_in = bl_dec;
               if (bl_dec == 7'd0) begin
                  group_in = sh_val;
                  phase_in = PH_START;
               end
            end
         end
         MODE_DELTA, MODE_GAMMA: begin
            if (phase_ff == PH_START) begin
               if (!b) begin
                  if (zero_run_ff != LEN_MAX) begin
                     zero_run_in = zero_run_ff + 7'd1;
                  end
               end else if (zero_run_ff == 7'd0) begin
                  emit   = 1'b1;
                  emit_n = ONE;
               end else begin
                  accum_in     = ONE;
                  bits_left_in = zero_run_ff;
                  zero_run_in  = 7'd0;
                  phase_in     = PH_FIELD;
               end
            end else begin
               accum_in     = sh_val;
               sticky_mid   = sticky_ff | sh_ovf;
               bits_left_in = bl_dec;
               if (bl_dec == 7'd0) begin
                  if (mode_ff == MODE_DELTA && phase_ff == PH_FIELD) begin
                     if (sh_val <= ONE) begin
                        emit     = 1'b1;
                        emit_n   = ONE;
                        phase_in = PH_START;
                     end else begin
                        bits_left_in = cap_len(sh_val - ONE);
                        accum_in     = ONE;
                        phase_in     = PH_TAIL;
                     end
                  end else begin
                     emit     = 1'b1;
                     emit_n   = sh_val;
                     accum_in = '0;
                     phase_in = PH_START;
                  end
               end
            end
         end
         default: begin
            if (b && prev_one_ff) begin
               emit        = 1'b1;
               emit_n      = fib_sum_ff;
               fib_lo_in   = ONE;
               fib_hi_in   = TWO;
               fib_sum_in  = '0;
               prev_one_in = 1'b0;
            end else begin
               if (b) begin
                  if (fib_lo_ff == VMAX || sum_add[W]) begin
                     sticky_mid = 1'b1;
                     fib_sum_in = VMAX;
                  end else begin
                     fib_sum_in = sum_add[W-1:0];
                  end
               end
               prev_one_in = b;
               fib_lo_in   = fib_hi_ff;
               fib_hi_in   = wgt_add[W] ? VMAX : wgt_add[W-1:0];
            end
         end
      endcase

      sticky_in = emit ? 1'b0 : sticky_mid;
      if (sticky_mid) begin
         emit_v = VMAX;
      end else if (emit_n != '0) begin
         emit_v = emit_n - ONE;
      end else begin
         emit_v = '0;
      end
      emit_ext       = EW'(emit_v);
      new_item.value = emit_ext[OUT_WIDTH-1:0];
      new_item.ovf   = sticky_mid;
      new_item.last  = last_bit;

      if (!step) begin
         phase_in     = phase_ff;
         zero_run_in  = zero_run_ff;
         bits_left_in = bits_left_ff;
         accum_in     = accum_ff;
         group_in     = group_ff;
         fib_lo_in    = fib_lo_ff;
         fib_hi_in    = fib_hi_ff;
         fib_sum_in   = fib_sum_ff;
         prev_one_in  = prev_one_ff;
         sticky_in    = sticky_ff;
      end

      if (csr_wr_en) begin
         mode_in      = csr_wr_data;
         phase_in     = PH_START;
         zero_run_in  = 7'd0;
         bits_left_in = 7'd0;
         accum_in     = '0;
         group_in     = ONE;
         fib_lo_in    = ONE;
         fib_hi_in    = TWO;
         fib_sum_in   = '0;
         prev_one_in  = 1'b0;
         sticky_in    = 1'b0;
      end
   end

   // one result is held back until the byte shows whether another follows
   always_comb begin
      held_last      = held_ff;
      held_last.last = 1'b1;
      held_valid_in  = held_valid_ff;
      held_in        = held_ff;
      push.push0     = 1'b0;
      push.push1     = 1'b0;
      push.item0     = held_ff;
      push.item1     = new_item;
      if (step) begin
         if (emit && held_valid_ff) begin
            push.push0 = 1'b1;
            if (last_bit) begin
               push.push1    = 1'b1;
               held_valid_in = 1'b0;
            end else begin
               held_in = new_item;
            end
         end else if (emit) begin
            if (last_bit) begin
               push.push0 = 1'b1;
               push.item0 = new_item;
            end else begin
               held_in       = new_item;
               held_valid_in = 1'b1;
            end
         end else if (held_valid_ff && last_bit) begin
            push.push0    = 1'b1;
            push.item0    = held_last;
            held_valid_in = 1'b0;
         end
      end
      if (csr_wr_en) begin
         held_valid_in = 1'b0;
      end
   end

   always_comb begin
      cur_in     = cur_ff;
      bit_idx_in = bit_idx_ff;
      have_in    = have_ff;
      if (in_pop) begin
         cur_in     = in_beat.data;
         bit_idx_in = 3'd7;
         have_in    = 1'b1;
      end else if (step && last_bit) begin
         have_in = 1'b0;
      end else if (step) begin
         bit_idx_in = bit_idx_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_OMEGA;
         phase_ff      <= PH_START;
         zero_run_ff   <= 7'd0;
         bits_left_ff  <= 7'd0;
         accum_ff      <= '0;
         group_ff      <= ONE;
         fib_lo_ff     <= ONE;
         fib_hi_ff     <= TWO;
         fib_sum_ff    <= '0;
         prev_one_ff   <= 1'b0;
         sticky_ff     <= 1'b0;
         held_valid_ff <= 1'b0;
         have_ff       <= 1'b0;
         bit_idx_ff    <= 3'd7;
      end else begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         zero_run_ff   <= zero_run_in;
         bits_left_ff  <= bits_left_in;
         accum_ff      <= accum_in;
         group_ff      <= group_in;
         fib_lo_ff     <= fib_lo_in;
         fib_hi_ff     <= fib_hi_in;
         fib_sum_ff    <= fib_sum_in;
         prev_one_ff   <= prev_one_in;
         sticky_ff     <= sticky_in;
         held_valid_ff <= held_valid_in;
         have_ff       <= have_in;
         bit_idx_ff    <= bit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      held_ff <= held_in;
   end

endmodule

FILE: hw/rtl/ucbd_rsp_queue.sv
module ucbd_rsp_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  ucbd_pkg::rsp_push_type            push,
   output logic                              room,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ucbd_pkg::OUT_WIDTH-1:0]    rsp_decoded_value,
   output logic                              rsp_overflow,
   output logic                              rsp_last_of_run
);
   import ucbd_pkg::*;

   rsp_item_type         q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rd_ff, rd_in;
   logic [RSP_PTR_W-1:0] wr_ff, wr_in;
   logic [RSP_PTR_W-1:0] wr_next;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RSP_CNT_W-1:0] n_push;
   logic                 pop;
   rsp_item_type         head;

   // two beats may enter in one cycle
   assign room      = (cnt_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign rsp_valid = (cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = q_ff[rd_ff];
   assign rsp_decoded_value = head.value;
   assign rsp_overflow      = head.ovf;
   assign rsp_last_of_run   = head.last;
   assign wr_next   = wr_ff + RSP_PTR_W'(1);
   assign n_push    = RSP_CNT_W'(push.push0) + RSP_CNT_W'(push.push1);

   always_comb begin
      wr_in  = wr_ff + n_push[RSP_PTR_W-1:0];
      rd_in  = pop ? rd_ff + RSP_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + n_push - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         q_ff[wr_ff] <= push.item0;
      end
      if (push.push1) begin
         q_ff[wr_next] <= push.item1;
      end
   end

endmodule

FILE: hw/rtl/universal_code_bitstream_decoder_top.sv
// Universal code bitstream decoder.
// req_*: packed code stream, one byte per beat, most significant bit first.
// rsp_*: one beat per completed code: the value minus one (saturated, with
//   rsp_overflow set, when it does not fit VALUE_WIDTH bits) and
//   rsp_last_of_run on the final value completed by an input byte.
// csr_*: code_mode write (0 omega, 1 delta, 2 gamma, 3 Fibonacci); a write
//   drops any unfinished code. Write only while no beat is in flight.
// Throughput: one stream bit per cycle through the bit-serial decoder while
//   the result queue has room; up to 8 result beats per byte.
// The last value completed by a byte waits for the byte's end, and a byte
//   queued behind others waits for each byte ahead of it.
// A two-entry byte queue sits in front of the decoder and a four-entry
//   result queue behind it. While rsp_stall is high the result queue fills,
//   the decoder holds on its current bit, then the byte queue fills and
//   req_stall rises. Reset empties both queues, selects omega and clears
//   all decoding state.
module universal_code_bitstream_decoder_top #(
   parameter int VALUE_WIDTH = ucbd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_stream_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ucbd_pkg::OUT_WIDTH-1:0] rsp_decoded_value,
   output logic                           rsp_overflow,
   output logic                           rsp_last_of_run,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_wr_data
);
   import ucbd_pkg::*;

   byte_beat_type beat;
   logic          pop;
   logic          room;
   rsp_push_type  push;

   ucbd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .beat            (beat),
      .pop             (pop)
   );

   ucbd_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_beat     (beat),
      .in_pop      (pop),
      .out_room    (room),
      .push        (push)
   );

   ucbd_rsp_queue u_rsp_queue (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .room              (room),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
